### rtl/core/xcfr_pkg.sv
// Shared types and constants for the XOR-checked frame receiver.
// Used by xcfr_ctrl, xcfr_datapath and xor_checked_frame_receiver; depends on nothing.
package xcfr_pkg;

  // Field widths of the item ports
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned LENGTH_W = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // Frame layout
  localparam int unsigned FRAME_OVERHEAD = 6;
  localparam int unsigned LENGTH_POS     = 4;
  localparam int unsigned CHECK_START    = 2;

  // Header register reset values
  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hCD;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hDC;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 1'b1;

  // Operation codes of an input item
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_REARM = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic take;     // input item accepted this cycle
    logic read_en;  // read frame store at the emit index
    logic advance;  // step the emit index
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_good;  // current input byte completes a frame with good check
    logic last;        // emit index is at the final frame byte
  } sts_t;

endpackage

### rtl/core/xcfr_datapath.sv
// Datapath: header registers, frame store, fill count, XOR check and emit index.
// Depends on xcfr_pkg.
module xcfr_datapath #(
  parameter int unsigned BufferBytes = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [xcfr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [xcfr_pkg::BYTE_W-1:0]           cfg_data_i,
  input  logic                                  operation_i,
  input  logic [xcfr_pkg::BYTE_W-1:0]           rx_byte_i,
  input  xcfr_pkg::cmd_t                        cmd_i,
  output xcfr_pkg::sts_t                        sts_o,
  output logic [xcfr_pkg::BYTE_W-1:0]           frame_byte_o,
  output logic [xcfr_pkg::INDEX_W-1:0]          byte_index_o,
  output logic [xcfr_pkg::LENGTH_W-1:0]         frame_length_o
);
  import xcfr_pkg::*;

  localparam int unsigned AddrW = (BufferBytes > 1) ? $clog2(BufferBytes) : 1;
  localparam int unsigned FillW = $clog2(BufferBytes + 1);
  localparam logic [FillW-1:0] FillMax = FillW'(BufferBytes);

  logic [BYTE_W-1:0] hdr_first_q, hdr_first_d;
  logic [BYTE_W-1:0] hdr_second_q, hdr_second_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [BYTE_W-1:0] check_q, check_d;
  logic [8:0]        len_q, len_d;
  logic [AddrW-1:0]  rd_idx_q, rd_idx_d;
  logic [BYTE_W-1:0] rd_data_q;
  logic [BYTE_W-1:0] mem [BufferBytes];

  logic              rearm;
  logic              is_first, is_second, is_body;
  logic              store_en, len_hit;
  logic [FillW-1:0]  fill_inc;
  logic [BYTE_W-1:0] check_new;
  logic [31:0]       rd_ext, fill_ext;

  // Configuration writes
  always_comb begin
    hdr_first_d  = hdr_first_q;
    hdr_second_d = hdr_second_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HEADER_FIRST:  hdr_first_d  = cfg_data_i;
        CFG_HEADER_SECOND: hdr_second_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame hunt decode
  assign rearm     = (operation_i == OP_REARM);
  assign fill_inc  = fill_q + FillW'(1);
  assign check_new = check_q ^ rx_byte_i;
  assign is_first  = (fill_q == '0) && (rx_byte_i == hdr_first_q);
  assign is_second = (fill_q == FillW'(1)) && (rx_byte_i == hdr_second_q);
  assign is_body   = (fill_q >= FillW'(CHECK_START)) && (fill_q < FillMax);
  assign store_en  = cmd_i.take && !rearm && (is_first || is_second || is_body);
  // length byte is only trusted once index 4 was written in this hunt
  assign len_hit   = is_body && (fill_inc >= FillW'(FRAME_OVERHEAD))
                     && (32'(len_q) == 32'(fill_inc));

  assign sts_o.frame_good = !rearm && len_hit && (check_new == '0);

  // Fill count, running check and length capture
  always_comb begin
    fill_d  = fill_q;
    check_d = check_q;
    len_d   = len_q;
    if (cmd_i.take) begin
      if (rearm) begin
        fill_d  = '0;
        check_d = '0;
      end else if (is_first) begin
        fill_d = FillW'(1);
      end else if (is_second) begin
        fill_d  = FillW'(2);
        check_d = '0;
      end else if (is_body) begin
        fill_d  = fill_inc;
        check_d = check_new;
        if (fill_q == FillW'(LENGTH_POS)) begin
          len_d = 9'(rx_byte_i) + 9'(FRAME_OVERHEAD);
        end
        // bad check: drop the frame and hunt again
        if (len_hit && (check_new != '0)) begin
          fill_d = '0;
        end
      end else begin
        fill_d = '0;
      end
    end
  end

  // Emit index
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.take) begin
      rd_idx_d = '0;
    end else if (cmd_i.advance) begin
      rd_idx_d = rd_idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HEADER_FIRST_RST;
      hdr_second_q <= HEADER_SECOND_RST;
      fill_q       <= '0;
      check_q      <= '0;
      rd_idx_q     <= '0;
    end else begin
      hdr_first_q  <= hdr_first_d;
      hdr_second_q <= hdr_second_d;
      fill_q       <= fill_d;
      check_q      <= check_d;
      rd_idx_q     <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[fill_q[AddrW-1:0]] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_en) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  // Output fields; fill count holds the frame length while emitting
  assign rd_ext         = 32'(rd_idx_q);
  assign fill_ext       = 32'(fill_q);
  assign sts_o.last     = ((rd_ext + 32'd1) == fill_ext);
  assign frame_byte_o   = rd_data_q;
  assign byte_index_o   = rd_ext[INDEX_W-1:0];
  assign frame_length_o = fill_ext[LENGTH_W-1:0];

endmodule

### rtl/core/xcfr_ctrl.sv
// Controller: sequences byte intake and frame emission.
// Depends on xcfr_pkg.
module xcfr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_stall_i,
  input  xcfr_pkg::sts_t sts_i,
  output xcfr_pkg::cmd_t cmd_o,
  output logic           in_stall_o,
  output logic           out_valid_o
);
  import xcfr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.frame_good) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_SHOW;
      ST_SHOW: begin
        if (!out_stall_i) begin
          state_d = sts_i.last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands and handshake
  assign cmd_o.take    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.read_en = (state_q == ST_READ);
  assign cmd_o.advance = (state_q == ST_SHOW) && !out_stall_i && !sts_i.last;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = (state_q == ST_SHOW);

endmodule

### rtl/core/xor_checked_frame_receiver.sv
// Top level of the XOR-checked frame receiver: controller plus datapath.
// Depends on xcfr_pkg, xcfr_ctrl and xcfr_datapath.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_stall_o   operation_i, rx_byte_i
//  out      output     out_valid_o/out_stall_i frame_byte_o, byte_index_o,
//                                              frame_length_o, last_o
//  cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// A received byte or rearm item is taken whenever the input is not stalled.
// A byte that completes a good frame starts its emission, with a frame store read
// state and an output state per byte, the output state held through output stalls;
// the input is stalled while the frame is emitted.
// Reset restores the header registers and clears the hunt; the store needs no clearing.
module xor_checked_frame_receiver #(
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [xcfr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [xcfr_pkg::BYTE_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic [xcfr_pkg::BYTE_W-1:0]        rx_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [xcfr_pkg::BYTE_W-1:0]        frame_byte_o,
  output logic [xcfr_pkg::INDEX_W-1:0]       byte_index_o,
  output logic [xcfr_pkg::LENGTH_W-1:0]      frame_length_o,
  output logic                               last_o
);
  import xcfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  xcfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  xcfr_datapath #(
    .BufferBytes (BUFFER_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .frame_byte_o   (frame_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o)
  );

  assign last_o = sts.last;

`ifndef SYNTHESIS
  // no intake while a frame is being emitted
  a_emit_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input not stalled during frame emission");

  // emission ends after the final byte is taken
  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o)
    else $error("output still valid after final frame byte");

  // a rearm item never starts an emission
  a_rearm_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (operation_i == OP_REARM)) |=> !in_stall_o)
    else $error("rearm item started frame emission");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for xor_checked_frame_receiver.
// Needs xcfr_pkg and the receiver RTL; feeds bytes and rearm items through the
// valid/stall ports and checks every emitted frame byte against a local deframer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import xcfr_pkg::*;

  localparam int unsigned STORE_BYTES = 64;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 2 * STORE_BYTES + 8;

  // One emitted frame byte
  typedef struct packed {
    logic [BYTE_W-1:0]   frame_byte;
    logic [INDEX_W-1:0]  byte_index;
    logic [LENGTH_W-1:0] frame_length;
    logic                last;
  } frame_beat_t;

  // Directed row: item plus, where typed, the number of frame bytes it must release
  typedef struct packed {
    logic                op;
    logic [BYTE_W-1:0]   rx;
    logic                typed;
    logic [LENGTH_W-1:0] beats;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 26;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{OP_BYTE,  8'h00, 1'b1, 7'd0},  // not a header, dropped
    '{OP_BYTE,  8'hCD, 1'b1, 7'd0},  // first header
    '{OP_BYTE,  8'h12, 1'b1, 7'd0},  // wrong second header, hunt restarts
    '{OP_BYTE,  8'hDC, 1'b1, 7'd0},  // second header alone is dropped
    '{OP_BYTE,  8'hCD, 1'b1, 7'd0},  // shortest frame, empty payload
    '{OP_BYTE,  8'hDC, 1'b1, 7'd0},
    '{OP_BYTE,  8'h01, 1'b1, 7'd0},
    '{OP_BYTE,  8'h02, 1'b1, 7'd0},
    '{OP_BYTE,  8'h00, 1'b1, 7'd0},
    '{OP_BYTE,  8'h03, 1'b1, 7'd6},
    '{OP_BYTE,  8'hFF, 1'b1, 7'd0},  // locked: stored behind the frame
    '{OP_REARM, 8'hFF, 1'b1, 7'd0},  // rearm ignores the byte field
    '{OP_BYTE,  8'hCD, 1'b0, 7'd0},  // bad check
    '{OP_BYTE,  8'hDC, 1'b0, 7'd0},
    '{OP_BYTE,  8'h00, 1'b0, 7'd0},
    '{OP_BYTE,  8'h00, 1'b0, 7'd0},
    '{OP_BYTE,  8'h00, 1'b0, 7'd0},
    '{OP_BYTE,  8'h01, 1'b1, 7'd0},
    '{OP_BYTE,  8'hCD, 1'b0, 7'd0},  // one payload byte, extreme values
    '{OP_BYTE,  8'hDC, 1'b0, 7'd0},
    '{OP_BYTE,  8'hFF, 1'b0, 7'd0},
    '{OP_BYTE,  8'h80, 1'b0, 7'd0},
    '{OP_BYTE,  8'h01, 1'b0, 7'd0},
    '{OP_BYTE,  8'h7F, 1'b0, 7'd0},
    '{OP_BYTE,  8'h01, 1'b1, 7'd7},
    '{OP_REARM, 8'h00, 1'b1, 7'd0}
  };

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_HEADER_FIRST;
  logic [BYTE_W-1:0]   cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                operation_i = OP_BYTE;
  logic [BYTE_W-1:0]   rx_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [BYTE_W-1:0]   frame_byte_o;
  logic [INDEX_W-1:0]  byte_index_o;
  logic [LENGTH_W-1:0] frame_length_o;
  logic                last_o;

  // Deframer state mirrored by the testbench
  logic [BYTE_W-1:0] hdr_first = HEADER_FIRST_RST;
  logic [BYTE_W-1:0] hdr_second = HEADER_SECOND_RST;
  logic [BYTE_W-1:0] byte_store [STORE_BYTES];
  int unsigned       hunt_fill = 0;
  logic [BYTE_W-1:0] hunt_xor = '0;

  frame_beat_t frame_bytes_due [$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  bit          no_gaps = 1'b0;
  bit          hold_request = 1'b0;

  xor_checked_frame_receiver #(
    .BUFFER_BYTES(STORE_BYTES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_byte_o  (frame_byte_o),
    .byte_index_o  (byte_index_o),
    .frame_length_o(frame_length_o),
    .last_o        (last_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Advance the deframer by one item; queue the frame bytes it releases
  function automatic int deframe_predict(input logic op, input logic [BYTE_W-1:0] b);
    frame_beat_t beat;
    int unsigned k;
    if (op == OP_REARM) begin
      hunt_fill = 0;
      hunt_xor = '0;
      return 0;
    end
    if (hunt_fill == 0 && b == hdr_first) begin
      byte_store[0] = b;
      hunt_fill = 1;
    end else if (hunt_fill == 1 && b == hdr_second) begin
      byte_store[1] = b;
      hunt_fill = 2;
      hunt_xor = '0;
    end else if (hunt_fill >= CHECK_START && hunt_fill < STORE_BYTES) begin
      byte_store[hunt_fill] = b;
      hunt_fill++;
      hunt_xor ^= b;
      if (hunt_fill >= FRAME_OVERHEAD &&
          int'(byte_store[LENGTH_POS]) + FRAME_OVERHEAD == hunt_fill) begin
        if (hunt_xor == '0) begin
          for (k = 0; k < hunt_fill; k++) begin
            beat.frame_byte   = byte_store[k];
            beat.byte_index   = k[INDEX_W-1:0];
            beat.frame_length = hunt_fill[LENGTH_W-1:0];
            beat.last         = (k + 1 == hunt_fill);
            frame_bytes_due.push_back(beat);
          end
          return hunt_fill;
        end
        hunt_fill = 0;
      end
    end else begin
      hunt_fill = 0;
    end
    return 0;
  endfunction

  // Offer one item after a random gap and predict it once accepted
  task automatic send_item(input logic op, input logic [BYTE_W-1:0] b, output int beats);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rx_byte_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats = deframe_predict(op, b);
    items_sent++;
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] b);
    int beats;
    send_item(OP_BYTE, b, beats);
  endtask

  task automatic put_rearm();
    int beats;
    send_item(OP_REARM, BYTE_W'($urandom_range(0, 255)), beats);
  endtask

  // Frame with payload length len_field; corrupt spoils the check byte
  task automatic send_frame(input int unsigned len_field, input bit corrupt);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] b;
    int unsigned k;
    acc = '0;
    put_byte(hdr_first);
    put_byte(hdr_second);
    for (k = CHECK_START; k < len_field + FRAME_OVERHEAD - 1; k++) begin
      b = (k == LENGTH_POS) ? len_field[BYTE_W-1:0] : BYTE_W'($urandom_range(0, 255));
      acc ^= b;
      put_byte(b);
    end
    if (corrupt) acc ^= BYTE_W'($urandom_range(1, 255));
    put_byte(acc);
  endtask

  // Noise bytes, with first headers mixed in
  task automatic send_noise(input int count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) put_byte(hdr_first);
      else put_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Half of the picks are well-formed frames, the rest broken frames, noise and rearms
  task automatic run_random_phase(input int goal);
    int start;
    int pick;
    logic [BYTE_W-1:0] b;
    start = items_sent;
    while (items_sent - start < goal) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 9) == 0) send_frame($urandom_range(0, 58), 1'b0);
        else send_frame($urandom_range(0, 9), 1'b0);
        if ($urandom_range(0, 3) != 0) put_rearm();
        else send_noise($urandom_range(1, 4));
      end else if (pick < 65) begin
        send_frame($urandom_range(0, 9), 1'b1);
      end else if (pick < 75) begin
        put_byte(hdr_first);
        b = BYTE_W'($urandom_range(0, 255));
        if (b == hdr_second) b ^= 8'h01;
        put_byte(b);
        send_noise($urandom_range(0, 3));
      end else if (pick < 90) begin
        send_noise($urandom_range(1, 6));
      end else begin
        put_rearm();
      end
    end
    no_gaps = 1'b0;
  endtask

  // Let every expected frame byte drain, then hold the input idle
  task automatic await_idle();
    in_valid_i <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_headers(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_HEADER_FIRST;
    cfg_data_i  <= first;
    @(posedge clk_i);
    hdr_first   = first;
    cfg_index_i <= CFG_HEADER_SECOND;
    cfg_data_i  <= second;
    @(posedge clk_i);
    hdr_second = second;
    cfg_we_i   <= 1'b0;
  endtask

  // Receiver: random stalls per frame byte, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        n = no_gaps ? 0 : $urandom_range(0, 4);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each accepted frame byte with the oldest expected one
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected frame byte %02h", frame_byte_o));
      end else begin
        want = frame_bytes_due.pop_front();
        if (frame_byte_o !== want.frame_byte)
          flag_mismatch($sformatf("frame_byte %02h, want %02h", frame_byte_o, want.frame_byte));
        if (byte_index_o !== want.byte_index)
          flag_mismatch($sformatf("byte_index %0d, want %0d", byte_index_o, want.byte_index));
        if (frame_length_o !== want.frame_length)
          flag_mismatch($sformatf("frame_length %0d, want %0d", frame_length_o,
                                  want.frame_length));
        if (last_o !== want.last)
          flag_mismatch($sformatf("last %b, want %b at index %0d", last_o, want.last,
                                  want.byte_index));
      end
    end
  end

  // Watchdog
  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

  // Stimulus
  initial begin
    int beats;
    int r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows under the reset headers
    for (r = 0; r < DIR_ROWS; r++) begin
      send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].rx, beats);
      if (DIRECTED_ROWS[r].typed && beats != int'(DIRECTED_ROWS[r].beats))
        flag_mismatch($sformatf("row %0d released %0d bytes, want %0d", r, beats,
                                DIRECTED_ROWS[r].beats));
    end

    // Longest frame fills the locked store; the next byte restarts the hunt,
    // then a new frame is accepted without rearm
    send_frame(STORE_BYTES - FRAME_OVERHEAD, 1'b0);
    put_byte(BYTE_W'($urandom_range(0, 255)));
    send_frame(0, 1'b0);
    put_rearm();

    // Extreme headers; long output hold-off backs up the input
    await_idle();
    set_headers(8'hFF, 8'h00);
    hold_request = 1'b1;
    send_frame(3, 1'b0);
    put_rearm();
    run_random_phase(8);

    await_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (frame_bytes_due.size() != 0)
      flag_mismatch($sformatf("%0d frame bytes never emitted", frame_bytes_due.size()));
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### files.f
rtl/core/xcfr_pkg.sv
rtl/core/xcfr_datapath.sv
rtl/core/xcfr_ctrl.sv
rtl/core/xor_checked_frame_receiver.sv
tb/testbench.sv
